// ===== src/idt_pkg.sv =====
// shared types, codes and helper functions for the distance transform unit
package idt_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 8;
	localparam logic [17:0] DIST_MAX = 18'h3FFFF;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_RUN  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] METRIC_EUCLID    = 2'd0;
	localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
	localparam logic [1:0] METRIC_CHESS     = 2'd2;

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_METRIC  = 2'd2;
	localparam logic [1:0] REG_INVERSE = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       mask_bit;
	} in_t;

	typedef struct packed {
		logic [17:0] distance;
		logic        done_res;
	} out_t;

	// one envelope entry: site column, segment start and column distance at the site
	typedef struct packed {
		logic [7:0]        site;
		logic signed [10:0] start;
		logic [9:0]        g;
	} env_t;

	function automatic logic [10:0] abs_diff(input logic signed [10:0] a, input logic [7:0] b);
		logic signed [11:0] d;
		d = 12'(a) - $signed({4'd0, b});
		abs_diff = d[11] ? 11'(-d) : d[10:0];
	endfunction

	// ordering key for manhattan and chessboard
	function automatic logic [23:0] fkey_lin(input logic [1:0] m, input logic signed [10:0] a,
			input logic [7:0] b, input logic [9:0] g);
		logic [10:0] dx;
		dx = abs_diff(a, b);
		if (m == METRIC_MANHATTAN) begin
			fkey_lin = 24'(dx) + 24'(g);
		end else begin
			fkey_lin = (dx > 11'(g)) ? 24'(dx) : 24'(g);
		end
	endfunction

	function automatic logic signed [21:0] sep_lin(input logic [1:0] m, input logic [7:0] i,
			input logic [7:0] u, input logic [9:0] gi, input logic [9:0] gu,
			input logic [9:0] inf);
		logic signed [21:0] si, su, sgi, sgu, sinf, mid, a, r;
		si   = $signed({14'd0, i});
		su   = $signed({14'd0, u});
		sgi  = $signed({12'd0, gi});
		sgu  = $signed({12'd0, gu});
		sinf = $signed({12'd0, inf});
		mid  = (si + su) >>> 1;
		if (m == METRIC_MANHATTAN) begin
			if (sgu >= sgi + su - si) begin
				r = sinf;
			end else if (sgi > sgu + su - si) begin
				r = -sinf;
			end else begin
				r = (sgu - sgi + su + si) >>> 1;
			end
		end else if (sgi <= sgu) begin
			a = si + sgu;
			r = (a > mid) ? a : mid;
		end else begin
			a = su - sgi;
			r = (a < mid) ? a : mid;
		end
		sep_lin = r;
	endfunction

	function automatic logic [17:0] lin_fixed(input logic [23:0] key);
		if (key > 24'(DIST_MAX >> FRAC_BITS)) begin
			lin_fixed = DIST_MAX;
		end else begin
			lin_fixed = 18'(key << FRAC_BITS);
		end
	endfunction

endpackage

// ===== src/idt_mac.sv =====
// shared signed multiply-accumulate unit
module idt_mac import idt_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic               clr,
	input  logic signed [11:0] a,
	input  logic signed [11:0] b,
	output logic signed [23:0] acc
);

	logic signed [23:0] acc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= (clr ? 24'sd0 : acc_q) + a * b;
		end
	end

	assign acc = acc_q;

endmodule

// ===== src/idt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module idt_div import idt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [21:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [21:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [10:0] rem_q;
	logic [21:0] quo_q;
	logic [9:0]  den_q;
	logic [10:0] trial;
	logic        ge;

	assign trial = {rem_q[9:0], quo_q[21]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd21;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[20:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/idt_sqrt.sv =====
// iterative integer square root, one root bit per cycle
module idt_sqrt import idt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] radicand,
	output logic        done,
	output logic [17:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [35:0] rad_q;
	logic [19:0] rem_q;
	logic [17:0] root_q;
	logic [21:0] cur;
	logic [21:0] trial;
	logic        ge;

	assign cur   = {rem_q, rad_q[35:34]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[33:0], 2'b00};
			rem_q  <= ge ? 20'(cur - trial) : cur[19:0];
			root_q <= {root_q[16:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/image_distance_transform_unit.sv =====
// load item: a new beat every cycle while no result waits on out_ready. read item: the result
// is read from the result memory and registered in RD_WAIT. run item: column pass down and up,
// then per row a forward envelope pass and a backward pass; for euclidean a separator
// waits on the divider and a pixel readout on the square root.
// reset clears control and sets the registers to 256 x 256, euclidean, not inverse;
// the pixel and envelope memories are undefined until written and are not cleared.
module image_distance_transform_unit import idt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_wdata
);

	typedef enum logic [4:0] {
		IDLE, RD_WAIT,
		C_DN_ADDR, C_DN_DATA, C_UP_ADDR, C_UP_DATA,
		R_INIT_ADDR, R_INIT_DATA,
		F_GU_ADDR, F_GU_DATA, F_ENV_ADDR, F_ENV_DATA,
		F_K1A, F_K1B, F_K2A, F_K2B, F_CMP,
		F_S1, F_S2, F_S3, F_SDIV, F_PUSH, F_NEXT,
		B_ENV_ADDR, B_ENV_DATA, B_K1, B_K2, B_SQS, B_SQW, B_WR
	} state_t;

	state_t state_q;

	logic [8:0] width_q, height_q;
	logic [1:0] metric_q;
	logic       inverse_q;

	logic [7:0]  row_q, col_q, q_q;
	logic [9:0]  prev_q, gu_q, gs_q;
	logic [7:0]  site_q;
	logic signed [10:0] start_q;
	logic [23:0] key1_q;
	logic signed [21:0] sep_q;
	logic        neg_q;
	logic        rd_inside_q;
	logic        out_valid_q;
	out_t        out_q;

	logic mask_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [9:0]  cd_mem  [MAX_WIDTH*MAX_HEIGHT];
	logic [17:0] res_mem [MAX_WIDTH*MAX_HEIGHT];
	env_t        env_mem [MAX_WIDTH];
	logic        mask_rd_q;
	logic [9:0]  cd_rd_q;
	logic [17:0] res_rd_q;
	env_t        env_rd_q;

	logic [8:0]  w_eff, h_eff;
	logic [7:0]  w_m1, h_m1;
	logic [9:0]  inf;
	logic [1:0]  m_eff;
	logic        eu;
	logic        in_acc, in_inside;
	logic [15:0] pix_addr, in_addr;
	logic        mask_we;
	logic        cd_we;
	logic [9:0]  cd_wdata, dn_val;
	logic        env_we;
	logic [7:0]  env_waddr;
	env_t        env_wdata;
	logic        res_we;
	logic [17:0] res_wdata;
	logic [23:0] k1, k2;
	logic        pop;
	logic signed [21:0] nw;
	logic        push_ok;
	logic signed [10:0] col_s;

	logic               mac_en, mac_clr;
	logic signed [11:0] mac_a, mac_b;
	logic signed [23:0] acc;
	logic signed [23:0] acc_abs;
	logic               div_start, div_done;
	logic [21:0]        quot;
	logic               sq_start, sq_done;
	logic [17:0]        root;

	assign w_eff = (width_q == 9'd0) ? 9'd1 : ((width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_q);
	assign h_eff = (height_q == 9'd0) ? 9'd1 :
		((height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_q);
	assign w_m1  = 8'(w_eff - 9'd1);
	assign h_m1  = 8'(h_eff - 9'd1);
	assign inf   = 10'(w_eff) + 10'(h_eff);
	assign m_eff = (metric_q == METRIC_EUCLID || metric_q == METRIC_MANHATTAN) ?
		metric_q : METRIC_CHESS;
	assign eu    = (m_eff == METRIC_EUCLID);

	assign in_ready  = (state_q == IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign in_inside = ({1'b0, in_data.pos_x} < w_eff) && ({1'b0, in_data.pos_y} < h_eff);
	assign pix_addr  = {row_q, col_q};
	assign in_addr   = {in_data.pos_y, in_data.pos_x};
	assign col_s     = $signed({3'd0, col_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 9'd256;
			height_q  <= 9'd256;
			metric_q  <= METRIC_EUCLID;
			inverse_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:   width_q   <= cfg_wdata;
				REG_HEIGHT:  height_q  <= cfg_wdata;
				REG_METRIC:  metric_q  <= cfg_wdata[1:0];
				REG_INVERSE: inverse_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// column pass value on the way down
	assign dn_val = (mask_rd_q == inverse_q) ? 10'd0 :
		((row_q == 8'd0) ? inf : prev_q + 10'd1);

	assign k1  = eu ? key1_q : fkey_lin(m_eff, start_q, site_q, gs_q);
	assign k2  = eu ? 24'(acc) : fkey_lin(m_eff, start_q, col_q, gu_q);
	assign pop = k1 > k2;
	assign nw  = sep_q + 22'sd1;
	assign push_ok = (nw < $signed({13'd0, w_eff})) && (({1'b0, q_q} + 9'd1) < w_eff);
	assign acc_abs = acc[23] ? -acc : acc;

	always_comb begin
		mask_we   = in_acc && (in_data.func == FUNC_LOAD) && in_inside;
		cd_we     = 1'b0;
		cd_wdata  = dn_val;
		env_we    = 1'b0;
		env_waddr = 8'd0;
		env_wdata = '{site: col_q, start: 11'sd0, g: gu_q};
		res_we    = (state_q == B_WR);
		res_wdata = eu ? root : lin_fixed(fkey_lin(m_eff, col_s, site_q, gs_q));
		case (state_q)
			C_DN_DATA: cd_we = 1'b1;
			C_UP_DATA: begin
				cd_we    = prev_q < cd_rd_q;
				cd_wdata = prev_q + 10'd1;
			end
			R_INIT_DATA: begin
				env_we    = 1'b1;
				env_wdata = '{site: 8'd0, start: 11'sd0, g: cd_rd_q};
			end
			F_CMP: env_we = pop && (q_q == 8'd0);
			F_PUSH: begin
				env_we    = push_ok;
				env_waddr = q_q + 8'd1;
				env_wdata = '{site: col_q, start: nw[10:0], g: gu_q};
			end
			default: ;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mac_en  = 1'b1;
		mac_clr = 1'b0;
		mac_a   = 12'sd0;
		mac_b   = 12'sd0;
		case (state_q)
			F_K1A: begin
				mac_clr = 1'b1;
				mac_a   = $signed({1'b0, abs_diff(start_q, site_q)});
				mac_b   = mac_a;
			end
			F_K1B, B_K2: begin
				mac_a = $signed({2'b0, gs_q});
				mac_b = mac_a;
			end
			F_K2A: begin
				mac_clr = 1'b1;
				mac_a   = $signed({1'b0, abs_diff(start_q, col_q)});
				mac_b   = mac_a;
			end
			F_K2B: begin
				mac_a = $signed({2'b0, gu_q});
				mac_b = mac_a;
			end
			F_S1: begin
				mac_clr = 1'b1;
				mac_a   = $signed({4'd0, col_q}) - $signed({4'd0, site_q});
				mac_b   = $signed({4'd0, col_q}) + $signed({4'd0, site_q});
			end
			F_S2: begin
				mac_a = $signed({2'b0, gu_q}) - $signed({2'b0, gs_q});
				mac_b = $signed({2'b0, gu_q}) + $signed({2'b0, gs_q});
			end
			B_K1: begin
				mac_clr = 1'b1;
				mac_a   = $signed({1'b0, abs_diff(col_s, site_q)});
				mac_b   = mac_a;
			end
			default: mac_en = 1'b0;
		endcase
	end

	assign div_start = (state_q == F_S3);
	assign sq_start  = (state_q == B_SQS);

	idt_mac u_mac (
		.clk (clk),
		.en  (mac_en),
		.clr (mac_clr),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	idt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_abs[21:0]),
		.divisor  ({1'b0, 8'(col_q - site_q), 1'b0}),
		.done     (div_done),
		.quotient (quot)
	);

	idt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({acc[19:0], 16'd0}),
		.done     (sq_done),
		.root     (root)
	);

	// memories
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[in_addr] <= in_data.mask_bit;
		end
		mask_rd_q <= mask_mem[pix_addr];
	end

	always_ff @(posedge clk) begin
		if (cd_we) begin
			cd_mem[pix_addr] <= cd_wdata;
		end
		cd_rd_q <= cd_mem[pix_addr];
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[pix_addr] <= res_wdata;
		end
		res_rd_q <= res_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (env_we) begin
			env_mem[env_waddr] <= env_wdata;
		end
		env_rd_q <= env_mem[q_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			q_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_acc) begin
						rd_inside_q <= in_inside;
						if (in_data.func == FUNC_RUN) begin
							row_q   <= '0;
							col_q   <= '0;
							state_q <= C_DN_ADDR;
						end else if (in_data.func == FUNC_READ) begin
							state_q <= RD_WAIT;
						end
					end
				end
				RD_WAIT: begin
					out_q       <= '{distance: rd_inside_q ? res_rd_q : 18'd0, done_res: 1'b0};
					out_valid_q <= 1'b1;
					state_q     <= IDLE;
				end
				C_DN_ADDR: state_q <= C_DN_DATA;
				C_DN_DATA: begin
					prev_q <= dn_val;
					if (row_q == h_m1) begin
						if (h_m1 == 8'd0) begin
							row_q <= '0;
							if (col_q == w_m1) begin
								col_q   <= '0;
								state_q <= R_INIT_ADDR;
							end else begin
								col_q   <= col_q + 8'd1;
								state_q <= C_DN_ADDR;
							end
						end else begin
							row_q   <= h_m1 - 8'd1;
							state_q <= C_UP_ADDR;
						end
					end else begin
						row_q   <= row_q + 8'd1;
						state_q <= C_DN_ADDR;
					end
				end
				C_UP_ADDR: state_q <= C_UP_DATA;
				C_UP_DATA: begin
					prev_q <= (prev_q < cd_rd_q) ? prev_q + 10'd1 : cd_rd_q;
					if (row_q == 8'd0) begin
						if (col_q == w_m1) begin
							col_q   <= '0;
							state_q <= R_INIT_ADDR;
						end else begin
							col_q   <= col_q + 8'd1;
							state_q <= C_DN_ADDR;
						end
					end else begin
						row_q   <= row_q - 8'd1;
						state_q <= C_UP_ADDR;
					end
				end
				R_INIT_ADDR: state_q <= R_INIT_DATA;
				R_INIT_DATA: begin
					q_q <= '0;
					if (w_m1 == 8'd0) begin
						state_q <= B_ENV_ADDR;
					end else begin
						col_q   <= 8'd1;
						state_q <= F_GU_ADDR;
					end
				end
				F_GU_ADDR: state_q <= F_GU_DATA;
				F_GU_DATA, F_ENV_DATA: begin
					if (state_q == F_GU_DATA) begin
						gu_q <= cd_rd_q;
					end
					site_q  <= env_rd_q.site;
					start_q <= env_rd_q.start;
					gs_q    <= env_rd_q.g;
					state_q <= eu ? F_K1A : F_CMP;
				end
				F_ENV_ADDR: state_q <= F_ENV_DATA;
				F_K1A: state_q <= F_K1B;
				F_K1B: state_q <= F_K2A;
				F_K2A: begin
					key1_q  <= 24'(acc);
					state_q <= F_K2B;
				end
				F_K2B: state_q <= F_CMP;
				F_CMP: begin
					if (pop) begin
						if (q_q == 8'd0) begin
							state_q <= F_NEXT;
						end else begin
							q_q     <= q_q - 8'd1;
							state_q <= F_ENV_ADDR;
						end
					end else if (eu) begin
						state_q <= F_S1;
					end else begin
						sep_q   <= sep_lin(m_eff, site_q, col_q, gs_q, gu_q, inf);
						state_q <= F_PUSH;
					end
				end
				F_S1: state_q <= F_S2;
				F_S2: state_q <= F_S3;
				F_S3: begin
					neg_q   <= acc[23];
					state_q <= F_SDIV;
				end
				F_SDIV: begin
					if (div_done) begin
						sep_q   <= neg_q ? -$signed(quot) : $signed(quot);
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ok) begin
						q_q <= q_q + 8'd1;
					end
					state_q <= F_NEXT;
				end
				F_NEXT: begin
					if (col_q == w_m1) begin
						state_q <= B_ENV_ADDR;
					end else begin
						col_q   <= col_q + 8'd1;
						state_q <= F_GU_ADDR;
					end
				end
				B_ENV_ADDR: state_q <= B_ENV_DATA;
				B_ENV_DATA: begin
					site_q  <= env_rd_q.site;
					start_q <= env_rd_q.start;
					gs_q    <= env_rd_q.g;
					state_q <= eu ? B_K1 : B_WR;
				end
				B_K1: state_q <= B_K2;
				B_K2: state_q <= B_SQS;
				B_SQS: state_q <= B_SQW;
				B_SQW: begin
					if (sq_done) begin
						state_q <= B_WR;
					end
				end
				B_WR: begin
					if (start_q == col_s && q_q != 8'd0) begin
						q_q <= q_q - 8'd1;
					end
					if (col_q == 8'd0) begin
						if (row_q == h_m1) begin
							out_q       <= '{distance: 18'd0, done_res: 1'b1};
							out_valid_q <= 1'b1;
							state_q     <= IDLE;
						end else begin
							row_q   <= row_q + 8'd1;
							state_q <= R_INIT_ADDR;
						end
					end else begin
						col_q   <= col_q - 8'd1;
						state_q <= B_ENV_ADDR;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == IDLE)
		else $error("ready raised outside idle");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == F_SDIV)
		else $error("divider finished with no separator waiting");
	a_env_guard: assert property (@(posedge clk) disable iff (!arst_n)
		env_we |-> {1'b0, env_waddr} < w_eff)
		else $error("envelope write beyond the active width");
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.func == FUNC_RUN |=> state_q == C_DN_ADDR)
		else $error("run beat did not start the column pass");
`endif

endmodule

// ===== tb/sv/image_distance_transform_unit_tb.sv =====
// testbench for the distance transform unit: random mask images, transform runs and readback
`timescale 1ns / 100ps

module image_distance_transform_unit_tb;
	import idt_pkg::*;

	localparam logic [1:0] FUNC_UNUSED   = 2'd3;
	localparam logic [1:0] METRIC_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 200000;
	localparam int ITEM_GOAL   = 1450;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_wdata = '0;

	// predictor state
	bit          pix_mask [MAX_WIDTH*MAX_HEIGHT];
	int          col_dist [MAX_WIDTH*MAX_HEIGHT];
	logic [17:0] dist_store [MAX_WIDTH*MAX_HEIGHT];
	int          env_site [MAX_WIDTH];
	int          env_start [MAX_WIDTH];
	logic [8:0]  reg_w = 9'd256;
	logic [8:0]  reg_h = 9'd256;
	logic [1:0]  reg_metric = METRIC_EUCLID;
	logic        reg_inv = 1'b0;

	in_t  stim [$];
	out_t dist_q [$];
	out_t want;
	int   errors = 0;
	int   n_items = 0;
	int   n_runs = 0;
	int   n_reads = 0;
	int   n_settings = 0;
	int   idle_mode = 0;
	int   quiet = 0;

	image_distance_transform_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic int eff_dim(logic [8:0] r);
		if (r == 0) return 1;
		return (r > 256) ? 256 : int'(r);
	endfunction

	function automatic longint pair_key(logic [1:0] m, longint x, longint xi, longint g);
		longint dx;
		dx = (x > xi) ? x - xi : xi - x;
		if (m == METRIC_EUCLID) return dx * dx + g * g;
		if (m == METRIC_MANHATTAN) return dx + g;
		return (dx > g) ? dx : g;
	endfunction

	function automatic longint split_point(logic [1:0] m, longint i, longint u, longint gi,
			longint gu, longint inf);
		longint a, b;
		if (m == METRIC_EUCLID) return (u * u - i * i + gu * gu - gi * gi) / (2 * (u - i));
		if (m == METRIC_MANHATTAN) begin
			if (gu >= gi + u - i) return inf;
			if (gi > gu + u - i) return -inf;
			return (gu - gi + u + i) / 2;
		end
		b = (i + u) / 2;
		if (gi <= gu) begin
			a = i + gu;
			return (a > b) ? a : b;
		end
		a = u - gi;
		return (a < b) ? a : b;
	endfunction

	function automatic logic [17:0] to_q8(logic [1:0] m, longint key);
		longint unsigned v, n, r, t;
		if (key < 0) key = 0;
		if (m == METRIC_EUCLID) begin
			n = longint'(key) << (2 * FRAC_BITS);
			r = 0;
			for (int b = 20; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n) r = t;
			end
			v = r;
		end else begin
			v = longint'(key) << FRAC_BITS;
		end
		return (v > DIST_MAX) ? DIST_MAX : v[17:0];
	endfunction

	function automatic void run_scan();
		int w, h, q, s, idx, base;
		logic [1:0] m;
		longint inf, nw;
		w = eff_dim(reg_w);
		h = eff_dim(reg_h);
		m = (reg_metric == METRIC_UNUSED) ? METRIC_CHESS : reg_metric;
		inf = w + h;
		for (int x = 0; x < w; x++) begin
			for (int y = 0; y < h; y++) begin
				idx = y * MAX_WIDTH + x;
				if (pix_mask[idx] == reg_inv) col_dist[idx] = 0;
				else if (y == 0) col_dist[idx] = int'(inf);
				else col_dist[idx] = col_dist[idx - MAX_WIDTH] + 1;
			end
			for (int y = h - 2; y >= 0; y--) begin
				idx = y * MAX_WIDTH + x;
				if (col_dist[idx + MAX_WIDTH] < col_dist[idx])
					col_dist[idx] = col_dist[idx + MAX_WIDTH] + 1;
			end
		end
		for (int y = 0; y < h; y++) begin
			base = y * MAX_WIDTH;
			q = 0;
			env_site[0] = 0;
			env_start[0] = 0;
			for (int u = 1; u < w; u++) begin
				while (q >= 0 && pair_key(m, env_start[q], env_site[q],
						col_dist[base + env_site[q]]) > pair_key(m, env_start[q], u,
						col_dist[base + u]))
					q--;
				if (q < 0) begin
					q = 0;
					env_site[0] = u;
				end else begin
					nw = 1 + split_point(m, env_site[q], u, col_dist[base + env_site[q]],
						col_dist[base + u], inf);
					if (nw < w && q + 1 < w) begin
						q++;
						env_site[q] = u;
						env_start[q] = int'(nw);
					end
				end
			end
			for (int u = w - 1; u >= 0; u--) begin
				s = env_site[q];
				dist_store[base + u] = to_q8(m, pair_key(m, u, s, col_dist[base + s]));
				if (u == env_start[q] && q > 0) q--;
			end
		end
	endfunction

	function automatic void predict_beat(in_t it);
		out_t r;
		bit in_img;
		in_img = it.pos_x < eff_dim(reg_w) && it.pos_y < eff_dim(reg_h);
		case (it.func)
			FUNC_LOAD: if (in_img) pix_mask[it.pos_y * MAX_WIDTH + it.pos_x] = it.mask_bit;
			FUNC_RUN: begin
				run_scan();
				r.distance = '0;
				r.done_res = 1'b1;
				dist_q.push_back(r);
			end
			FUNC_READ: begin
				r.distance = in_img ? dist_store[it.pos_y * MAX_WIDTH + it.pos_x] : '0;
				r.done_res = 1'b0;
				dist_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task automatic flag_error(string what, longint exp_v, longint act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0d actual %0d at %0t", what, exp_v, act_v, $realtime);
	endtask

	// driver: presents queued items, holds each beat until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_beat(in_data);
			if (!in_valid || in_ready) begin
				if (stim.size() > 0 && !((idle_mode == 1 && $urandom_range(99) < 74) ||
						(idle_mode == 3 && $urandom_range(99) < 21))) begin
					in_valid <= 1'b1;
					in_data <= stim.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (dist_q.size() == 0) begin
					flag_error("unexpected result, distance", -1, out_data.distance);
				end else begin
					want = dist_q.pop_front();
					if (out_data.distance !== want.distance)
						flag_error("distance", want.distance, out_data.distance);
					if (out_data.done_res !== want.done_res)
						flag_error("done_res", want.done_res, out_data.done_res);
				end
			end
			out_ready <= !((idle_mode == 2 && $urandom_range(99) < 74) ||
				(idle_mode == 3 && $urandom_range(99) < 21));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout with %0d results outstanding", dist_q.size());
				$display("FAIL image_distance_transform_unit");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_WIDTH: reg_w = val;
			REG_HEIGHT: reg_h = val;
			REG_METRIC: reg_metric = val[1:0];
			REG_INVERSE: reg_inv = val[0];
			default: ;
		endcase
	endtask

	task automatic set_image(logic [8:0] w, logic [8:0] h, logic [1:0] m, logic inv);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_METRIC, {7'd0, m});
		write_reg(REG_INVERSE, {8'd0, inv});
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic put(logic [1:0] f, int x, int y, logic b);
		in_t it;
		it.func = f;
		it.pos_x = x[7:0];
		it.pos_y = y[7:0];
		it.mask_bit = b;
		stim.push_back(it);
		if (f != FUNC_UNUSED) n_items++;
		if (f == FUNC_RUN) n_runs++;
		if (f == FUNC_READ) n_reads++;
	endtask

	task automatic put_outside(logic [1:0] f);
		int w, h;
		w = eff_dim(reg_w);
		h = eff_dim(reg_h);
		if (w < 256) put(f, $urandom_range(255, w), $urandom_range(255), $urandom_range(1));
		else if (h < 256) put(f, $urandom_range(255), $urandom_range(255, h), $urandom_range(1));
	endtask

	// full load, run, readback, then for a random nonzero k a partial reload, run, readback
	task automatic fill_phase(int pct, int n_rd);
		int w, h, k;
		w = eff_dim(reg_w);
		h = eff_dim(reg_h);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				put(FUNC_LOAD, x, y, $urandom_range(99) < pct);
				if ($urandom_range(15) == 0) put_outside(FUNC_LOAD);
			end
		put(FUNC_RUN, $urandom_range(255), $urandom_range(255), $urandom_range(1));
		for (int i = 0; i < n_rd; i++) begin
			if ($urandom_range(9) == 0) put_outside(FUNC_READ);
			else put(FUNC_READ, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(1));
			if ($urandom_range(30) == 0)
				put(FUNC_UNUSED, $urandom_range(255), $urandom_range(255), $urandom_range(1));
		end
		k = $urandom_range(4);
		if (k > 0) begin
			for (int i = 0; i < k; i++)
				put(FUNC_LOAD, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(1));
			put(FUNC_RUN, 0, 0, 1'b0);
			for (int i = 0; i < n_rd / 2 + 1; i++)
				put(FUNC_READ, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(1));
		end
	endtask

	task automatic drain();
		while (stim.size() > 0 || in_valid || dist_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int pcts [5];
		int k;
		pcts = '{0, 10, 50, 90, 100};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at reset size, then a tiny image end to end
		put(FUNC_LOAD, 255, 255, 1'b1);
		put(FUNC_LOAD, 0, 0, 1'b0);
		put(FUNC_UNUSED, 255, 255, 1'b1);
		drain();
		set_image(9'd3, 9'd2, METRIC_EUCLID, 1'b0);
		put(FUNC_LOAD, 0, 0, 1'b0);
		put(FUNC_LOAD, 1, 0, 1'b1);
		put(FUNC_LOAD, 2, 0, 1'b1);
		put(FUNC_LOAD, 0, 1, 1'b1);
		put(FUNC_LOAD, 1, 1, 1'b1);
		put(FUNC_LOAD, 2, 1, 1'b1);
		put(FUNC_LOAD, 200, 1, 1'b0);
		put(FUNC_RUN, 0, 0, 1'b0);
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < 3; x++) put(FUNC_READ, x, y, 1'b0);
		put(FUNC_READ, 255, 255, 1'b1);
		put(FUNC_READ, 3, 0, 1'b0);
		put(FUNC_UNUSED, 1, 1, 1'b0);
		drain();

		// register extremes, including out of range sizes that clamp
		idle_mode = 3;
		set_image(9'd511, 9'd1, METRIC_EUCLID, 1'b0);
		fill_phase(20, 30);
		drain();
		idle_mode = 0;
		set_image(9'd0, 9'd256, METRIC_MANHATTAN, 1'b1);
		fill_phase(80, 30);
		drain();
		idle_mode = 1;
		set_image(9'd256, 9'd0, METRIC_UNUSED, 1'b1);
		fill_phase(50, 20);
		drain();

		k = 0;
		while (n_items < ITEM_GOAL) begin
			idle_mode = k % 4;
			set_image($urandom_range(12, 1), $urandom_range(12, 1), k % 4 == 0 ? METRIC_EUCLID :
				k % 4 == 1 ? METRIC_MANHATTAN : k % 4 == 2 ? METRIC_CHESS : METRIC_UNUSED,
				$urandom_range(1));
			fill_phase(pcts[$urandom_range(4)], $urandom_range(30, 8));
			drain();
			k++;
		end
		repeat (50) @(posedge clk);

		$display("covered %0d items in %0d register settings: %0d transform runs, %0d reads",
			n_items, n_settings, n_runs, n_reads);
		$display("all four metric codes, both mask polarities, mismatches %0d", errors);
		if (errors == 0) begin
			$display("PASS image_distance_transform_unit");
		end else begin
			$display("FAIL image_distance_transform_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/idt_pkg.sv
src/idt_mac.sv
src/idt_div.sv
src/idt_sqrt.sv
src/image_distance_transform_unit.sv
tb/sv/image_distance_transform_unit_tb.sv
